@@ design/imh_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imh_pkg
// Operation and status codes and field widths of the indexed min-heap.
// ----------------------------------------------------------------------------
package imh_pkg;

    localparam int ITEM_W   = 10;
    localparam int KEYF_W   = 16;
    localparam int SLOTF_W  = 10;
    localparam int HSIZE_W  = 11;

    typedef enum logic [1:0] {
        OP_CHANGE  = 2'd0,
        OP_EXTRACT = 2'd1,
        OP_REMOVE  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_REMOVED = 2'd2,
        ST_RANGE   = 2'd3
    } status_t;

endpackage
`default_nettype wire

@@ design/imh_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imh_ram
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
module imh_ram #(
    parameter int AW = 10,
    parameter int DW = 26
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] wa,
    input  wire logic [DW-1:0] wd,
    input  wire logic [AW-1:0] ra,
    output logic      [DW-1:0] rd
);

    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd <= mem[ra];
    end

endmodule
`default_nettype wire

@@ design/indexed_min_heap.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_min_heap
// Indexed binary min-heap of item ids with an item-to-slot map.
// ----------------------------------------------------------------------------
// One item at a time. The heap entries (item, key) and the item-to-slot map
// sit in two memories with registered reads. A change with an equal key
// reads the slot, then the entry, and then loads the result register. A sift
// walks one level going down with one or two child reads and a compare, and
// going up with a parent read and a compare; remove may add a sift up after a
// sift down that did not move. After reset a clearing pass loads both
// memories with the identity layout; no item is taken during it.
// ----------------------------------------------------------------------------
module indexed_min_heap
    import imh_pkg::*;
#(
    parameter int CAPACITY = 1024,
    parameter int KEY_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // item[9:0], key[25:10], zero pad
    input  wire logic [1:0]  s_tuser,   // operation[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // result_item[9:0], result_key[25:10], slot[35:26]
    output logic [1:0]       m_tuser,   // status[1:0]
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [10:0] cfg_data   // heap_size[10:0]
);

    localparam int SW = $clog2(CAPACITY);
    localparam int NW = $clog2(CAPACITY + 1);
    localparam int MW = (NW > HSIZE_W) ? NW : HSIZE_W;
    localparam int WW = MW + 2;
    localparam int DW = SW + KEY_BITS;

    typedef enum logic [13:0] {
        S_CLEAR   = 14'b00000000000001,
        S_IDLE    = 14'b00000000000010,
        S_POS     = 14'b00000000000100,
        S_CK      = 14'b00000000001000,
        S_TO1     = 14'b00000000010000,
        S_TO2     = 14'b00000000100000,
        S_SD_CALC = 14'b00000001000000,
        S_SD_C1   = 14'b00000010000000,
        S_SD_C2   = 14'b00000100000000,
        S_SD_END  = 14'b00001000000000,
        S_SU_CALC = 14'b00010000000000,
        S_SU_CMP  = 14'b00100000000000,
        S_SU_END  = 14'b01000000000000,
        S_OUT     = 14'b10000000000000
    } state_t;

    state_t                state_reg, state_next;
    logic [HSIZE_W-1:0]    hs_reg, hs_next;
    logic [MW-1:0]         rem_reg, rem_next;
    logic [SW-1:0]         clr_reg, clr_next;
    op_t                   op_reg, op_next;
    logic [SW-1:0]         item_reg, item_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [SW-1:0]         s_reg, s_next;
    logic [SW-1:0]         par_reg, par_next;
    logic [SW-1:0]         cs_reg, cs_next;
    logic [DW-1:0]         c1_reg, c1_next;
    logic                  single_reg, single_next;
    logic [SW-1:0]         mv_item_reg, mv_item_next;
    logic [KEY_BITS-1:0]   mv_key_reg, mv_key_next;
    logic [SW-1:0]         org_reg, org_next;
    logic [MW-1:0]         hb_reg, hb_next;
    logic                  tk_reg, tk_next;
    logic [ITEM_W-1:0]     r_item_reg, r_item_next;
    logic [KEYF_W-1:0]     r_key_reg, r_key_next;
    logic [SLOTF_W-1:0]    r_slot_reg, r_slot_next;
    status_t               r_st_reg, r_st_next;
    logic                  m_valid_reg, m_valid_next;
    logic [39:0]           m_data_reg, m_data_next;
    logic [1:0]            m_user_reg, m_user_next;

    logic                  h_we, p_we;
    logic [SW-1:0]         h_wa, h_ra, p_wa, p_ra, p_wd, p_rd;
    logic [DW-1:0]         h_wd, h_rd;

    logic [MW-1:0]         hs_ext, n_w, nm1, item_ext, sp_ext, up_pos;
    logic [WW-1:0]         cw, csw;
    op_t                   op_in;
    logic [DW-1:0]         ch_e;
    logic [SW-1:0]         ch_s;
    logic [KEY_BITS-1:0]   h_rd_key;
    logic [SW-1:0]         h_rd_item;

    imh_ram #(.AW(SW), .DW(DW)) u_heap (
        .clk (clk),
        .we  (h_we),
        .wa  (h_wa),
        .wd  (h_wd),
        .ra  (h_ra),
        .rd  (h_rd)
    );

    imh_ram #(.AW(SW), .DW(SW)) u_pos (
        .clk (clk),
        .we  (p_we),
        .wa  (p_wa),
        .wd  (p_wd),
        .ra  (p_ra),
        .rd  (p_rd)
    );

    assign hs_ext    = MW'(hs_reg);
    assign n_w       = (hs_reg == '0) ? MW'(1)
                     : ((hs_ext > MW'(CAPACITY)) ? MW'(CAPACITY) : hs_ext);
    assign nm1       = n_w - MW'(1);
    assign item_ext  = MW'(s_tdata[9:0]);
    assign sp_ext    = MW'(p_rd);
    assign up_pos    = nm1 - MW'(s_reg);
    assign cw        = ((WW'(nm1) - WW'(s_reg)) << 1) + WW'(1);
    assign csw       = WW'(nm1) - cw;
    assign op_in     = op_t'(s_tuser[1:0]);
    assign h_rd_key  = h_rd[KEY_BITS-1:0];
    assign h_rd_item = h_rd[DW-1:KEY_BITS];

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_user_reg;

    always_comb
    begin
        if (state_reg == S_SD_C2 && c1_reg[KEY_BITS-1:0] > h_rd_key)
        begin
            ch_e = h_rd;
            ch_s = cs_reg - SW'(1);
        end
        else if (state_reg == S_SD_C2)
        begin
            ch_e = c1_reg;
            ch_s = cs_reg;
        end
        else
        begin
            ch_e = h_rd;
            ch_s = cs_reg;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        hs_next      = hs_reg;
        rem_next     = rem_reg;
        clr_next     = clr_reg;
        op_next      = op_reg;
        item_next    = item_reg;
        key_next     = key_reg;
        s_next       = s_reg;
        par_next     = par_reg;
        cs_next      = cs_reg;
        c1_next      = c1_reg;
        single_next  = single_reg;
        mv_item_next = mv_item_reg;
        mv_key_next  = mv_key_reg;
        org_next     = org_reg;
        hb_next      = hb_reg;
        tk_next      = tk_reg;
        r_item_next  = r_item_reg;
        r_key_next   = r_key_reg;
        r_slot_next  = r_slot_reg;
        r_st_next    = r_st_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        h_we = 1'b0;
        h_wa = s_reg;
        h_wd = {mv_item_reg, mv_key_reg};
        h_ra = s_reg;
        p_we = 1'b0;
        p_wa = mv_item_reg;
        p_wd = s_reg;
        p_ra = item_reg;

        if (cfg_valid)
        begin
            hs_next = cfg_data;
        end
        if (m_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                h_we = 1'b1;
                h_wa = clr_reg;
                h_wd = {clr_reg, {KEY_BITS{1'b0}}};
                p_we = 1'b1;
                p_wa = clr_reg;
                p_wd = clr_reg;
                clr_next = clr_reg + SW'(1);
                if (clr_reg == SW'(CAPACITY - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next     = op_in;
                    item_next   = item_ext[SW-1:0];
                    key_next    = KEY_BITS'(s_tdata[25:10]);
                    r_item_next = s_tdata[9:0];
                    r_key_next  = '0;
                    r_slot_next = '0;
                    r_st_next   = ST_OK;
                    case (op_in) inside
                        OP_EXTRACT:
                        begin
                            r_item_next = '0;
                            if (rem_reg >= n_w)
                            begin
                                r_st_next  = ST_EMPTY;
                                state_next = S_OUT;
                            end
                            else
                            begin
                                s_next     = nm1[SW-1:0];
                                h_ra       = nm1[SW-1:0];
                                state_next = S_TO1;
                            end
                        end
                        OP_CHANGE, OP_REMOVE:
                        begin
                            if (item_ext >= n_w)
                            begin
                                r_st_next  = ST_RANGE;
                                state_next = S_OUT;
                            end
                            else
                            begin
                                p_ra       = item_ext[SW-1:0];
                                state_next = S_POS;
                            end
                        end
                        default:
                        begin
                            r_item_next = '0;
                            state_next  = S_OUT;
                        end
                    endcase
                end
            end
            S_POS:
            begin
                if (sp_ext >= n_w)
                begin
                    r_st_next  = ST_RANGE;
                    state_next = S_OUT;
                end
                else if (sp_ext < rem_reg)
                begin
                    r_st_next  = ST_REMOVED;
                    state_next = S_OUT;
                end
                else
                begin
                    s_next     = p_rd;
                    h_ra       = p_rd;
                    state_next = (op_reg == OP_CHANGE) ? S_CK : S_TO1;
                end
            end
            S_CK:
            begin
                mv_item_next = h_rd_item;
                mv_key_next  = key_reg;
                r_key_next   = KEYF_W'(key_reg);
                tk_next      = 1'b0;
                if (key_reg == h_rd_key)
                begin
                    r_slot_next = SLOTF_W'(s_reg);
                    state_next  = S_OUT;
                end
                else if (key_reg < h_rd_key)
                begin
                    state_next = S_SU_CALC;
                end
                else
                begin
                    hb_next    = rem_reg;
                    state_next = S_SD_CALC;
                end
            end
            S_TO1:
            begin
                c1_next    = h_rd;
                h_ra       = rem_reg[SW-1:0];
                state_next = S_TO2;
            end
            S_TO2:
            begin
                h_we = 1'b1;
                h_wa = rem_reg[SW-1:0];
                h_wd = c1_reg;
                p_we = 1'b1;
                p_wa = c1_reg[DW-1:KEY_BITS];
                p_wd = rem_reg[SW-1:0];
                rem_next     = rem_reg + MW'(1);
                r_item_next  = ITEM_W'(c1_reg[DW-1:KEY_BITS]);
                r_key_next   = KEYF_W'(c1_reg[KEY_BITS-1:0]);
                r_slot_next  = SLOTF_W'(rem_reg);
                mv_item_next = h_rd_item;
                mv_key_next  = h_rd_key;
                tk_next      = 1'b1;
                org_next     = s_reg;
                hb_next      = rem_reg + MW'(1);
                state_next   = (MW'(s_reg) == rem_reg) ? S_OUT : S_SD_CALC;
            end
            S_SD_CALC:
            begin
                if (cw + WW'(hb_reg) > WW'(nm1))
                begin
                    state_next = S_SD_END;
                end
                else
                begin
                    cs_next     = csw[SW-1:0];
                    h_ra        = csw[SW-1:0];
                    single_next = (csw == WW'(hb_reg));
                    state_next  = S_SD_C1;
                end
            end
            S_SD_C1, S_SD_C2:
            begin
                c1_next = (state_reg == S_SD_C1) ? h_rd : c1_reg;
                if (state_reg == S_SD_C1 && !single_reg)
                begin
                    h_ra       = cs_reg - SW'(1);
                    state_next = S_SD_C2;
                end
                else if (ch_e[KEY_BITS-1:0] < mv_key_reg)
                begin
                    h_we = 1'b1;
                    h_wa = s_reg;
                    h_wd = ch_e;
                    p_we = 1'b1;
                    p_wa = ch_e[DW-1:KEY_BITS];
                    p_wd = s_reg;
                    s_next     = ch_s;
                    state_next = S_SD_CALC;
                end
                else
                begin
                    state_next = S_SD_END;
                end
            end
            S_SD_END:
            begin
                if (tk_reg && s_reg == org_reg)
                begin
                    state_next = S_SU_CALC;
                end
                else
                begin
                    h_we = 1'b1;
                    p_we = 1'b1;
                    if (!tk_reg)
                    begin
                        r_slot_next = SLOTF_W'(s_reg);
                    end
                    state_next = S_OUT;
                end
            end
            S_SU_CALC:
            begin
                if (MW'(s_reg) < nm1)
                begin
                    par_next   = SW'(nm1 - ((up_pos - MW'(1)) >> 1));
                    h_ra       = SW'(nm1 - ((up_pos - MW'(1)) >> 1));
                    state_next = S_SU_CMP;
                end
                else
                begin
                    state_next = S_SU_END;
                end
            end
            S_SU_CMP:
            begin
                if (h_rd_key <= mv_key_reg)
                begin
                    state_next = S_SU_END;
                end
                else
                begin
                    h_we = 1'b1;
                    h_wa = s_reg;
                    h_wd = h_rd;
                    p_we = 1'b1;
                    p_wa = h_rd_item;
                    p_wd = s_reg;
                    s_next     = par_reg;
                    state_next = S_SU_CALC;
                end
            end
            S_SU_END:
            begin
                h_we = 1'b1;
                p_we = 1'b1;
                if (!tk_reg)
                begin
                    r_slot_next = SLOTF_W'(s_reg);
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {4'd0, r_slot_reg, r_key_reg, r_item_reg};
                    m_user_next  = r_st_reg;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            hs_reg      <= HSIZE_W'(1024);
            rem_reg     <= '0;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            hs_reg      <= hs_next;
            rem_reg     <= rem_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        item_reg    <= item_next;
        key_reg     <= key_next;
        s_reg       <= s_next;
        par_reg     <= par_next;
        cs_reg      <= cs_next;
        c1_reg      <= c1_next;
        single_reg  <= single_next;
        mv_item_reg <= mv_item_next;
        mv_key_reg  <= mv_key_next;
        org_reg     <= org_next;
        hb_reg      <= hb_next;
        tk_reg      <= tk_next;
        r_item_reg  <= r_item_next;
        r_key_reg   <= r_key_next;
        r_slot_reg  <= r_slot_next;
        r_st_reg    <= r_st_next;
        m_data_reg  <= m_data_next;
        m_user_reg  <= m_user_next;
    end

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("item accepted while previous item still in work");

    a_take_out_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TO2) |=> (rem_reg == $past(rem_reg) + MW'(1)))
        else $error("removed boundary did not advance on take out");

    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == S_OUT))
        else $error("result raised outside of result state");

endmodule
`default_nettype wire
